@@ rtl/oadc_pkg.sv @@
// oadc_pkg: shared types and constants of the oversampling adc channel filter
// used by oadc_div, oadc_ctrl, oadc_datapath and the top level; no dependencies
package oadc_pkg;

  localparam int unsigned SampleW   = 12;
  localparam int unsigned ChanW     = 3;
  localparam int unsigned BitsW     = 4;
  localparam int unsigned SumW      = 20;
  localparam int unsigned LenW      = 9;
  localparam int unsigned MaskW     = 8;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned ReadW     = 16;
  localparam int unsigned DivW      = SumW + 4;
  localparam int unsigned DivCntW   = $clog2(DivW);
  localparam int unsigned ShiftW    = 5;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 9;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned OutDataW  = 32;

  localparam logic [LenW-1:0]    MaxLen     = 9'd256;
  localparam logic [ByteW-1:0]   LowClear   = 8'hff;
  localparam logic [ShiftW-1:0]  HfPoint    = 5'd19;
  localparam logic [ShiftW-1:0]  NormPoint  = 5'd17;

  localparam logic [CfgIdxW-1:0] CfgBlockLength  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHighfreqMask = 2'd1;

  localparam logic OpSample = 1'b0;
  localparam logic OpQuery  = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StSample,
    StLoad,
    StDiv,
    StFinish
  } state_e;

  typedef struct packed {
    logic capture;
    logic sample_upd;
    logic div_load;
    logic div_step;
    logic emit_query;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

@@ rtl/oadc_div.sv @@
// oadc_div: restoring divider, one quotient bit per cycle while step_i is high
// depends on oadc_pkg
module oadc_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  logic                            step_i,
  input  logic [oadc_pkg::DivW-1:0]       dividend_i,
  input  logic [oadc_pkg::LenW-1:0]       divisor_i,
  output logic [oadc_pkg::DivW-1:0]       quotient_o,
  output logic                            last_o
);

  logic [oadc_pkg::DivW-1:0]    quo_q, quo_d;
  logic [oadc_pkg::LenW-1:0]    rem_q, rem_d;
  logic [oadc_pkg::LenW-1:0]    dsr_q;
  logic [oadc_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [oadc_pkg::LenW:0]      trial;
  logic                         ge;

  assign trial = {rem_q, quo_q[oadc_pkg::DivW-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (load_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = '0;
    end else if (step_i) begin
      quo_d = {quo_q[oadc_pkg::DivW-2:0], ge};
      rem_d = ge ? oadc_pkg::LenW'(trial - {1'b0, dsr_q}) : oadc_pkg::LenW'(trial);
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (load_i) begin
      dsr_q <= divisor_i;
    end
  end

  assign quotient_o = quo_q;
  assign last_o     = cnt_q == oadc_pkg::DivCntW'(oadc_pkg::DivW - 1);

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> rem_q < dsr_q)
    else $error("divider remainder not below divisor");
  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> cnt_q < oadc_pkg::DivCntW'(oadc_pkg::DivW))
    else $error("divider stepped past its last bit");
  a_load_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> cnt_q == '0)
    else $error("divider load did not restart the count");
`endif

endmodule

@@ rtl/oadc_ctrl.sv @@
// oadc_ctrl: sequencer for sample updates and divided queries
// depends on oadc_pkg
module oadc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_op_i,
  output logic                  in_ready_o,
  input  oadc_pkg::ctrl_sts_t   sts_i,
  output oadc_pkg::ctrl_cmd_t   cmd_o
);

  oadc_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      oadc_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = (in_op_i == oadc_pkg::OpQuery) ? oadc_pkg::StLoad : oadc_pkg::StSample;
        end
      end
      oadc_pkg::StSample: begin
        if (sts_i.out_free) begin
          state_d = oadc_pkg::StIdle;
        end
      end
      oadc_pkg::StLoad:   state_d = oadc_pkg::StDiv;
      oadc_pkg::StDiv: begin
        if (sts_i.div_last) begin
          state_d = oadc_pkg::StFinish;
        end
      end
      oadc_pkg::StFinish: begin
        if (sts_i.out_free) begin
          state_d = oadc_pkg::StIdle;
        end
      end
      default: state_d = oadc_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      oadc_pkg::StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      oadc_pkg::StSample: cmd_o.sample_upd = sts_i.out_free;
      oadc_pkg::StLoad:   cmd_o.div_load   = 1'b1;
      oadc_pkg::StDiv:    cmd_o.div_step   = 1'b1;
      oadc_pkg::StFinish: cmd_o.emit_query = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oadc_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_emit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.sample_upd || cmd_o.emit_query) |-> sts_i.out_free)
    else $error("result emitted into a full output register");
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == oadc_pkg::StSample || state_q == oadc_pkg::StLoad))
    else $error("accepted item did not start work");
  a_load_then_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_load |=> cmd_o.div_step)
    else $error("divider load not followed by a step");
`endif

endmodule

@@ rtl/oadc_datapath.sv @@
// oadc_datapath: configuration registers, per-channel accumulators, output register
// depends on oadc_pkg and oadc_div
module oadc_datapath #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  oadc_pkg::ctrl_cmd_t                 cmd_i,
  output oadc_pkg::ctrl_sts_t                 sts_o,
  input  logic [oadc_pkg::ChanW-1:0]          in_channel_i,
  input  logic [oadc_pkg::SampleW-1:0]        in_sample_i,
  input  logic [oadc_pkg::BitsW-1:0]          in_bits_i,
  input  logic                                cfg_we_i,
  input  logic [oadc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [oadc_pkg::CfgDataW-1:0]       cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                out_done_o,
  output logic [oadc_pkg::ReadW-1:0]          out_read_o,
  output logic [oadc_pkg::ByteW-1:0]          out_range_o
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [oadc_pkg::LenW-1:0]    blen_q;
  logic [oadc_pkg::MaskW-1:0]   hfmask_q;

  logic [oadc_pkg::ChanW-1:0]   ch_q;
  logic [oadc_pkg::SampleW-1:0] smp_q;
  logic [oadc_pkg::BitsW-1:0]   bits_q;

  logic [oadc_pkg::LenW-1:0]    cd_q    [CHANNELS];
  logic [oadc_pkg::SumW-1:0]    sum_q   [CHANNELS];
  logic [oadc_pkg::ByteW-1:0]   high_q  [CHANNELS];
  logic [oadc_pkg::ByteW-1:0]   low_q   [CHANNELS];
  logic [oadc_pkg::SumW-1:0]    lsum_q  [CHANNELS];
  logic [oadc_pkg::ByteW-1:0]   lrange_q[CHANNELS];

  logic                         ch_ok, hf;
  logic [IdxW-1:0]              idx;
  logic [oadc_pkg::LenW-1:0]    eff_len;
  logic [oadc_pkg::ByteW-1:0]   smp_byte;
  logic [oadc_pkg::DivW-1:0]    quotient;
  logic [oadc_pkg::ShiftW-1:0]  sh;
  logic [oadc_pkg::DivW+2:0]    wide;
  logic [oadc_pkg::ReadW-1:0]   scaled;
  logic                         div_last;

  logic                         out_valid_q;
  logic                         out_done_q;
  logic [oadc_pkg::ReadW-1:0]   out_read_q;
  logic [oadc_pkg::ByteW-1:0]   out_range_q;

  assign ch_ok    = 32'(ch_q) < CHANNELS;
  assign idx      = ch_ok ? IdxW'(ch_q) : '0;
  assign hf       = hfmask_q[ch_q];
  assign smp_byte = smp_q[9:2];

  always_comb begin
    if (hf) begin
      eff_len = oadc_pkg::LenW'(1);
    end else if (blen_q == '0) begin
      eff_len = oadc_pkg::LenW'(1);
    end else if (blen_q > oadc_pkg::MaxLen) begin
      eff_len = oadc_pkg::MaxLen;
    end else begin
      eff_len = blen_q;
    end
  end

  // config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blen_q   <= oadc_pkg::LenW'(1);
      hfmask_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        oadc_pkg::CfgBlockLength:  blen_q   <= cfg_data_i;
        oadc_pkg::CfgHighfreqMask: hfmask_q <= cfg_data_i[oadc_pkg::MaskW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ch_q   <= in_channel_i;
      smp_q  <= in_sample_i;
      bits_q <= in_bits_i;
    end
  end

  // per-channel accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cd_q[i]     <= '0;
        sum_q[i]    <= '0;
        high_q[i]   <= '0;
        low_q[i]    <= '0;
        lsum_q[i]   <= '0;
        lrange_q[i] <= '0;
      end
    end else if (cmd_i.sample_upd && ch_ok) begin
      if (cd_q[idx] != '0) begin
        cd_q[idx]  <= cd_q[idx] - 1'b1;
        sum_q[idx] <= sum_q[idx] + oadc_pkg::SumW'(smp_q);
        if (smp_byte > high_q[idx]) begin
          high_q[idx] <= smp_byte;
        end
        if (smp_byte < low_q[idx]) begin
          low_q[idx] <= smp_byte;
        end
      end else begin
        lsum_q[idx]   <= sum_q[idx];
        lrange_q[idx] <= high_q[idx] - low_q[idx];
        cd_q[idx]     <= eff_len;
        sum_q[idx]    <= '0;
        high_q[idx]   <= '0;
        low_q[idx]    <= oadc_pkg::LowClear;
      end
    end
  end

  oadc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (cmd_i.div_load),
    .step_i     (cmd_i.div_step),
    .dividend_i ({lsum_q[idx], 4'b0000}),
    .divisor_i  (eff_len),
    .quotient_o (quotient),
    .last_o     (div_last)
  );

  // q * 8 shifted right by point - bits covers both directions
  assign sh     = (hf ? oadc_pkg::HfPoint : oadc_pkg::NormPoint) - oadc_pkg::ShiftW'(bits_q);
  assign wide   = {quotient, 3'b000} >> sh;
  assign scaled = wide[oadc_pkg::ReadW-1:0];

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.sample_upd || cmd_i.emit_query) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sample_upd) begin
      out_done_q  <= ch_ok && (cd_q[idx] == '0);
      out_read_q  <= '0;
      out_range_q <= '0;
    end else if (cmd_i.emit_query) begin
      out_done_q  <= 1'b0;
      out_read_q  <= ch_ok ? scaled : '0;
      out_range_q <= ch_ok ? lrange_q[idx] : '0;
    end
  end

  assign sts_o.div_last = div_last;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_done_o  = out_done_q;
  assign out_read_o  = out_read_q;
  assign out_range_o = out_range_q;

`ifndef SYNTHESIS
  a_query_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_query |=> !out_done_q)
    else $error("query result flagged a closed block");
  a_sample_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sample_upd |=> out_read_q == '0 && out_range_q == '0)
    else $error("sample result carries query fields");
  a_close_reloads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.sample_upd && ch_ok && cd_q[idx] == '0) |=> cd_q[$past(idx)] != '0)
    else $error("closed block did not reload its countdown");
`endif

endmodule

@@ rtl/oversampling_adc_channel_filter.sv @@
// oversampling_adc_channel_filter: multi-channel oversampling accumulator, top level
// depends on oadc_pkg, oadc_ctrl, oadc_datapath and oadc_div
//
// Input stream: each transaction is a sample (tuser op 0) or a query (op 1) for one
// channel. One result transaction comes out for every input transaction, in order.
// A sample adds to the channel sum and range trackers, or closes the block when the
// channel countdown is zero (block_done set). A query returns the latched range and
// the latched sum divided by block length (1 if highfreq), scaled to requested bits.
// A sample is captured, then written to the output register once that is free; the
// controller then goes back to idle and takes the next item. A query first loads a
// one-bit-per-cycle restoring divider (24 steps) and runs it, then its result is
// written once the output register is free, and only then is the next item taken.
// The output register holds a finished result while the receiver stalls; the next
// item is still accepted, and its result waits until the register is taken.
// Configuration: index 0 block_length, index 1 highfreq_mask; always ready, write
// only while idle. Reset clears all channel state, block_length 1, mask 0, and
// no result is pending afterwards.
module oversampling_adc_channel_filter #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // channel[2:0], sample[14:3], bits[18:15], zero fill
  input  logic [oadc_pkg::InDataW-1:0]     s_axis_tdata,
  // op[0]
  input  logic [0:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // block_done[0], scaled_read[16:1], peak_range[24:17], zero fill
  output logic [oadc_pkg::OutDataW-1:0]    m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [oadc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [oadc_pkg::CfgDataW-1:0]    cfg_data_i
);

  oadc_pkg::ctrl_cmd_t          cmd;
  oadc_pkg::ctrl_sts_t          sts;
  logic                         out_done;
  logic [oadc_pkg::ReadW-1:0]   out_read;
  logic [oadc_pkg::ByteW-1:0]   out_range;

  assign cfg_ready_o = 1'b1;

  oadc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  oadc_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_channel_i (s_axis_tdata[2:0]),
    .in_sample_i  (s_axis_tdata[14:3]),
    .in_bits_i    (s_axis_tdata[18:15]),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_done_o   (out_done),
    .out_read_o   (out_read),
    .out_range_o  (out_range)
  );

  assign m_axis_tdata = {7'b0000000, out_range, out_read, out_done};

endmodule
